// ===== rtl/tabe_pkg.sv =====
package tabe_pkg;

  localparam int unsigned DataW = 8;
  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [2:0] {
    MODE_DOUT    = 3'd0,
    MODE_PWM     = 3'd1,
    MODE_CLOCK   = 3'd2,
    MODE_COMBINE = 3'd3,
    MODE_ONOFF   = 3'd4,
    MODE_COUNTER = 3'd5,
    MODE_WAVE    = 3'd6,
    MODE_NONE    = 3'd7
  } mode_t;

  localparam logic [2:0] REG_MODE    = 3'd0;
  localparam logic [2:0] REG_SUBOP   = 3'd1;
  localparam logic [2:0] REG_PFIRST  = 3'd2;
  localparam logic [2:0] REG_PSECOND = 3'd3;
  localparam logic [2:0] REG_STEP    = 3'd4;
  localparam logic [2:0] REG_RELOAD  = 3'd5;
  localparam logic [2:0] REG_OPERAND = 3'd6;

  localparam logic [4:0] OP_COPY = 5'd0;
  localparam logic [4:0] OP_LT   = 5'd1;
  localparam logic [4:0] OP_GT   = 5'd2;
  localparam logic [4:0] OP_EQ   = 5'd3;
  localparam logic [4:0] OP_NE   = 5'd4;
  localparam logic [4:0] OP_GE   = 5'd5;
  localparam logic [4:0] OP_LE   = 5'd6;
  localparam logic [4:0] OP_DIVS = 5'd7;
  localparam logic [4:0] OP_NDIV = 5'd8;
  localparam logic [4:0] OP_MUL  = 5'd9;
  localparam logic [4:0] OP_DIV  = 5'd10;
  localparam logic [4:0] OP_SADD = 5'd11;
  localparam logic [4:0] OP_SSUB = 5'd12;
  localparam logic [4:0] OP_ABV  = 5'd13;
  localparam logic [4:0] OP_BLW  = 5'd14;
  localparam logic [4:0] OP_INV  = 5'd15;

  localparam logic [4:0] CMB_AND = 5'd0;
  localparam logic [4:0] CMB_OR  = 5'd1;
  localparam logic [4:0] CMB_XOR = 5'd2;
  localparam logic [4:0] CMB_IF  = 5'd3;
  localparam logic [4:0] CMB_IFN = 5'd4;
  localparam logic [4:0] CMB_MAX = 5'd5;
  localparam logic [4:0] CMB_MIN = 5'd6;
  localparam logic [4:0] CMB_SUB = 5'd7;
  localparam logic [4:0] CMB_ADD = 5'd8;

  localparam logic [4:0] DIR_UP     = 5'd0;
  localparam logic [4:0] DIR_DOWN   = 5'd1;
  localparam logic [4:0] DIR_BOUNCE = 5'd2;

  localparam logic [4:0] WAVE_SAW_UP = 5'd0;
  localparam logic [4:0] WAVE_SAW_DN = 5'd1;
  localparam logic [4:0] WAVE_TRI    = 5'd2;

  localparam logic [5:0] SecPerMin = 6'd60;
  localparam logic [4:0] HrPerDay  = 5'd24;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DONE,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [7:0] new_value;
    logic       drive_valid;
    logic [7:0] drive_level;
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic [7:0] next_time;
  } result_t;

  typedef struct packed {
    logic       source_valid;
    logic [7:0] source_value_a;
    logic [7:0] source_value_b;
  } item_t;

endpackage

// ===== rtl/tabe_if.sv =====
interface tabe_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/timed_action_block_engine_top.sv =====
// Timed action block engine: one item is one timer expiry of an action block
// and returns exactly one result item. The configured mode selects digital or
// PWM output through a byte evaluator, a virtual h:m:s clock, a two-input
// combiner, an on/off timer, an up/down/bounce counter or a sawtooth/triangle
// waveform, and every result carries the next timer reload code. With the
// receiver ready, an item passes through the states idle, div and out, with
// done between div and out when the evaluator operator needs a quotient or
// remainder: the shared restoring divider produces one quotient bit a cycle.
// The block takes one item at a time; the next item is accepted once the
// result has been taken. Configuration must be written only while the block
// is idle; the block itself does not enforce this.
module timed_action_block_engine_top
  import tabe_pkg::*;
#(
  parameter int unsigned SECOND_TICK_CODE = 129
) (
  input  logic         clk,
  input  logic         rst_n,
  tabe_if.sink         in_ch,
  tabe_if.source       out_ch,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [7:0]   cfg_data
);
  localparam logic [7:0] TickCode = SECOND_TICK_CODE[7:0];

  // configuration registers
  mode_t      mode_r;
  logic [4:0] subop_r;
  logic [7:0] pfirst_r, psecond_r, step_r, reload_r, operand_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_DOUT;
      subop_r   <= '0;
      pfirst_r  <= '0;
      psecond_r <= 8'd255;
      step_r    <= 8'd1;
      reload_r  <= '0;
      operand_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:    mode_r    <= mode_t'(cfg_data[2:0]);
        REG_SUBOP:   subop_r   <= cfg_data[4:0];
        REG_PFIRST:  pfirst_r  <= cfg_data;
        REG_PSECOND: psecond_r <= cfg_data;
        REG_STEP:    step_r    <= cfg_data;
        REG_RELOAD:  reload_r  <= cfg_data;
        REG_OPERAND: operand_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // block state
  logic [7:0] value_r, value_nxt;
  logic       crise_r, crise_nxt, wrise_r, wrise_nxt;
  logic [4:0] hr_r, hr_nxt;
  logic [5:0] min_r, min_nxt, sec_r, sec_nxt;
  state_t     state_r, state_nxt;
  item_t      item_r;
  result_t    res_r, res_nxt;

  // shared divider; its quotient and remainder are final in the done cycle
  logic       div_start, div_done;
  logic [7:0] div_q, div_rem;

  tabe_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .dividend(item_r.source_value_a), .divisor(operand_r),
    .done(div_done), .quotient(div_q), .remainder(div_rem)
  );

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign out_ch.valid = (state_r == ST_OUT);
  assign out_ch.data  = res_r;

  logic needs_div;
  assign needs_div = (mode_r == MODE_DOUT || mode_r == MODE_PWM) &&
                     (subop_r == OP_DIVS || subop_r == OP_NDIV || subop_r == OP_DIV) &&
                     (operand_r != 8'd0);

  always_comb begin
    state_nxt = state_r;
    div_start = 1'b0;
    unique case (state_r)
      ST_IDLE: if (in_ch.valid) state_nxt = ST_DIV;
      ST_DIV: begin
        if (needs_div && item_r.source_valid) begin
          div_start = 1'b1;
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_DONE: if (div_done) state_nxt = ST_OUT;
      ST_OUT: if (out_ch.ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // evaluator
  logic [7:0] a, b, k, ev;
  logic [8:0] sum9;
  logic [15:0] prod;
  always_comb begin
    a    = item_r.source_value_a;
    b    = item_r.source_value_b;
    k    = operand_r;
    sum9 = {1'b0, a} + {1'b0, k};
    prod = a * k;
    case (subop_r)
      OP_COPY: ev = a;
      OP_LT:   ev = {7'd0, a < k};
      OP_GT:   ev = {7'd0, a > k};
      OP_EQ:   ev = {7'd0, a == k};
      OP_NE:   ev = {7'd0, a != k};
      OP_GE:   ev = {7'd0, a >= k};
      OP_LE:   ev = {7'd0, a <= k};
      OP_DIVS: ev = {7'd0, (k != 8'd0) && (div_rem == 8'd0)};
      OP_NDIV: ev = {7'd0, (k == 8'd0) || (div_rem != 8'd0)};
      OP_MUL:  ev = prod[7:0];
      OP_DIV:  ev = (k == 8'd0) ? 8'd0 : div_q;
      OP_SADD: ev = sum9[8] ? 8'd255 : sum9[7:0];
      OP_SSUB: ev = (a >= k) ? (a - k) : 8'd0;
      OP_ABV:  ev = (a > k) ? a : 8'd0;
      OP_BLW:  ev = (a < k) ? a : 8'd0;
      OP_INV:  ev = 8'd255 - a;
      default: ev = 8'd1;
    endcase
  end

  // action per mode, evaluated when the result is formed
  logic [7:0] cmb, lvl, nxt;
  logic       dv;
  logic [5:0] sec_inc, min_inc;
  logic [4:0] hr_inc;
  always_comb begin
    value_nxt = value_r;
    crise_nxt = crise_r;
    wrise_nxt = wrise_r;
    hr_nxt    = hr_r;
    min_nxt   = min_r;
    sec_nxt   = sec_r;
    dv        = 1'b0;
    lvl       = '0;
    nxt       = '0;
    sec_inc   = sec_r + 6'd1;
    min_inc   = min_r + 6'd1;
    hr_inc    = hr_r + 5'd1;
    case (subop_r)
      CMB_AND: cmb = {7'd0, (a != 8'd0) && (b != 8'd0)};
      CMB_OR:  cmb = {7'd0, (a != 8'd0) || (b != 8'd0)};
      CMB_XOR: cmb = a ^ b;
      CMB_IF:  cmb = (a != 8'd0) ? b : 8'd0;
      CMB_IFN: cmb = (a != 8'd0) ? 8'd0 : b;
      CMB_MAX: cmb = (a > b) ? a : b;
      CMB_MIN: cmb = (a < b) ? a : b;
      CMB_SUB: cmb = a - b;
      CMB_ADD: cmb = a + b;
      default: cmb = 8'd0;
    endcase
    case (mode_r)
      MODE_DOUT, MODE_PWM: begin
        if (item_r.source_valid) begin
          dv        = 1'b1;
          lvl       = (mode_r == MODE_PWM && ev == 8'd1) ? 8'd255 : ev;
          value_nxt = lvl;
        end
        nxt = reload_r;
      end
      MODE_CLOCK: begin
        sec_nxt = sec_inc;
        if (sec_inc >= SecPerMin) begin
          sec_nxt = '0;
          min_nxt = min_inc;
          if (min_inc >= SecPerMin) begin
            min_nxt = '0;
            hr_nxt  = (hr_inc >= HrPerDay) ? 5'd0 : hr_inc;
          end
        end
        nxt = TickCode;
      end
      MODE_COMBINE: begin
        value_nxt = cmb;
        nxt       = reload_r;
      end
      MODE_ONOFF: begin
        if (value_r != 8'd0) begin
          value_nxt = 8'd0;
          nxt       = psecond_r;
        end else begin
          value_nxt = 8'd1;
          nxt       = pfirst_r;
        end
      end
      MODE_COUNTER: begin
        if (subop_r == DIR_UP || (subop_r == DIR_BOUNCE && crise_r)) begin
          if (value_r < psecond_r) value_nxt = value_r + step_r;
          else begin
            value_nxt = pfirst_r;
            if (subop_r == DIR_BOUNCE) crise_nxt = 1'b0;
          end
        end else if (subop_r == DIR_DOWN || subop_r == DIR_BOUNCE) begin
          if (value_r > pfirst_r) value_nxt = value_r - step_r;
          else begin
            value_nxt = psecond_r;
            if (subop_r == DIR_BOUNCE) crise_nxt = 1'b1;
          end
        end
        nxt = reload_r;
      end
      MODE_WAVE: begin
        if (subop_r == WAVE_SAW_UP) begin
          value_nxt = ((8'd255 - value_r) > pfirst_r) ? value_r + pfirst_r : 8'd0;
        end else if (subop_r == WAVE_SAW_DN) begin
          value_nxt = (value_r > pfirst_r) ? value_r - pfirst_r : 8'd255;
        end else if (subop_r == WAVE_TRI) begin
          if (wrise_r) begin
            if (value_r < psecond_r) value_nxt = value_r + pfirst_r;
            else begin
              value_nxt = 8'd0;
              wrise_nxt = 1'b0;
            end
          end else begin
            if (value_r > pfirst_r) value_nxt = value_r - pfirst_r;
            else begin
              value_nxt = 8'd255;
              wrise_nxt = 1'b1;
            end
          end
        end
        nxt = reload_r;
      end
      default: ;
    endcase
    res_nxt.new_value   = value_nxt;
    res_nxt.drive_valid = dv;
    res_nxt.drive_level = lvl;
    res_nxt.hours       = hr_nxt;
    res_nxt.minutes     = min_nxt;
    res_nxt.seconds     = sec_nxt;
    res_nxt.next_time   = nxt;
  end

  logic commit;
  assign commit = (state_nxt == ST_OUT) && (state_r != ST_OUT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      value_r <= '0;
      crise_r <= 1'b0;
      wrise_r <= 1'b1;
      hr_r    <= '0;
      min_r   <= '0;
      sec_r   <= '0;
    end else begin
      state_r <= state_nxt;
      // update block state as the result is formed
      if (commit) begin
        value_r <= value_nxt;
        crise_r <= crise_nxt;
        wrise_r <= wrise_nxt;
        hr_r    <= hr_nxt;
        min_r   <= min_nxt;
        sec_r   <= sec_nxt;
      end
    end
    if (in_ch.valid && in_ch.ready) item_r <= in_ch.data;
    if (commit) res_r <= res_nxt;
  end
endmodule

// ===== rtl/tabe_div.sv =====
module tabe_div
  import tabe_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [7:0] dividend,
  input  logic [7:0] divisor,
  output logic       done,
  output logic [7:0] quotient,
  output logic [7:0] remainder
);
  logic [7:0] quo_r, quo_nxt, rem_r, rem_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic       busy_r, busy_nxt;
  logic [8:0] trial;

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    trial    = {rem_r, quo_r[7]} - {1'b0, divisor};
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = 4'd8;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // restoring step: one quotient bit per cycle
      if (!trial[8]) begin
        rem_nxt = trial[7:0];
        quo_nxt = {quo_r[6:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[6:0], quo_r[7]};
        quo_nxt = {quo_r[6:0], 1'b0};
      end
      cnt_nxt = cnt_r - 4'd1;
      if (cnt_r == 4'd1) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign done      = busy_r && (cnt_r == 4'd1);
  assign quotient  = quo_nxt;
  assign remainder = rem_nxt;
endmodule
